/* hw/rtl/umau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package umau_pkg;

   localparam int unsigned RAM_WORDS_DEFAULT      = 65536;
   localparam int unsigned PHYS_ADDR_BITS_DEFAULT = 30;

   localparam int unsigned ADDR_W     = 30;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned RAM_BYTES_W = 19;
   localparam logic [RAM_BYTES_W-1:0] RAM_BYTES_RESET = 19'h40000;

   // Access size codes; code three is handled as a longword.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SECOND,
      ST_WRBACK
   } umau_state_type;

   typedef struct packed {
      logic we;
      logic re;
   } umau_ram_ctl_type;

   function automatic logic [31:0] lane_mask(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_WORD: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] extract(input logic [63:0] pair, input logic [1:0] bo,
                                           input logic [1:0] size);
      logic [63:0] sh;
      sh = pair >> {bo, 3'b000};
      return sh[31:0] & lane_mask(size);
   endfunction

   function automatic logic [63:0] merge(input logic [63:0] pair, input logic [31:0] data,
                                         input logic [1:0] bo, input logic [1:0] size);
      logic [63:0] m;
      logic [63:0] d;
      m = {32'h0, lane_mask(size)} << {bo, 3'b000};
      d = {32'h0, data & lane_mask(size)} << {bo, 3'b000};
      return (pair & ~m) | d;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/umau_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module umau_ram #(
   parameter int unsigned DEPTH  = umau_pkg::RAM_WORDS_DEFAULT,
   parameter int unsigned IDX_W  = 16
) (
   input  wire                          clock,
   input  wire umau_pkg::umau_ram_ctl_type ctl,
   input  wire        [IDX_W-1:0]       addr,
   input  wire        [31:0]            wdata,
   output logic       [31:0]            rdata
);
   import umau_pkg::*;

   logic [31:0] mem [DEPTH];

   // Single port; the read data register holds its value when no read is issued.
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[addr] <= wdata;
      end
      if (ctl.re) begin
         rdata <= mem[addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/unaligned_memory_access_unit_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tdata: phys_address, write_data
//                                            tuser: command, size_code
// rsp_      out        rsp_tvalid/tready     tdata: read_data; tuser: io_access
// csr_      in         csr_we                csr_wdata: ram_bytes
//
// An access that stays inside one longword, and every I/O access, ends in the first step.
// A read that crosses a longword boundary ends in the second step, a crossing write in
// the write-back step. The extra steps come from the single RAM port, which reads or
// writes one longword at a time. Reset is synchronous and clears only control state and
// ram_bytes; RAM contents are undefined until written. A stalled result beat holds the
// block in its final step, and the next beat is taken once the result is parked.

module unaligned_memory_access_unit_core #(
   parameter int unsigned RAM_WORDS      = umau_pkg::RAM_WORDS_DEFAULT,
   parameter int unsigned PHYS_ADDR_BITS = umau_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [29:0] phys_address, [61:30] write_data, zero pad
   input  wire  [2:0]  req_tuser,   // [0] command, [2:1] size_code
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_data
   output logic        rsp_tuser,   // [0] io_access
   input  wire         csr_we,
   input  wire  [umau_pkg::RAM_BYTES_W-1:0] csr_wdata
);
   import umau_pkg::*;

   localparam int unsigned IDX_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
   localparam logic [31:0] AMASK = (PHYS_ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                   : 32'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
   localparam logic [29:0] WMASK = AMASK[31:2];

   // Configuration register.
   logic [RAM_BYTES_W-1:0] ram_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_bytes_ff <= RAM_BYTES_RESET;
      end else if (csr_we) begin
         ram_bytes_ff <= csr_wdata;
      end
   end

   // Decode of the incoming beat.
   logic        accept;
   logic [31:0] in_addr;
   logic [1:0]  in_bo;
   logic [1:0]  in_size;
   logic [29:0] in_w0;
   logic [29:0] in_w1;
   logic        in_two;
   logic        in_io;

   function automatic logic word_in_ram(input logic [29:0] w, input logic [18:0] rb);
      return (w < 30'(RAM_WORDS)) && ({w, 2'b11} < {13'h0, rb});
   endfunction

   assign accept  = req_tvalid && req_tready;
   assign in_addr = {2'b00, req_tdata[29:0]} & AMASK;
   assign in_bo   = in_addr[1:0];
   assign in_size = req_tuser[2:1];
   assign in_w0   = in_addr[31:2];
   assign in_w1   = (in_w0 + 30'd1) & WMASK;

   // A word crosses only from the last byte lane; a longword from any unaligned lane.
   always_comb begin
      case (in_size)
         SIZE_BYTE: in_two = 1'b0;
         SIZE_WORD: in_two = (in_bo == 2'd3);
         default:   in_two = (in_bo != 2'd0);
      endcase
   end

   assign in_io = !word_in_ram(in_w0, ram_bytes_ff)
                  || (in_two && !word_in_ram(in_w1, ram_bytes_ff));

   // Item registers.
   logic             item_cmd_ff;
   logic [31:0]      item_data_ff;
   logic [1:0]       item_size_ff;
   logic [1:0]       item_bo_ff;
   logic             item_two_ff;
   logic             item_io_ff;
   logic [IDX_W-1:0] item_w0_ff;
   logic [IDX_W-1:0] item_w1_ff;
   logic [31:0]      word0_ff;
   logic [31:0]      word0_in;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff  <= req_tuser[0];
         item_data_ff <= req_tdata[61:30];
         item_size_ff <= in_size;
         item_bo_ff   <= in_bo;
         item_two_ff  <= in_two;
         item_io_ff   <= in_io;
         item_w0_ff   <= in_w0[IDX_W-1:0];
         item_w1_ff   <= in_w1[IDX_W-1:0];
      end
      word0_ff <= word0_in;
   end

   // Sequencer.
   umau_state_type   state_ff;
   umau_state_type   state_in;
   umau_ram_ctl_type ram_ctl;
   logic [IDX_W-1:0] ram_addr;
   logic [31:0]      ram_wdata;
   logic [31:0]      ram_rdata;
   logic             produce;
   logic             slot_free;
   logic [63:0]      pair;
   logic [63:0]      merged;
   logic [31:0]      result_data;

   assign slot_free = !rsp_tvalid || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // In the first step only the first longword is on hand; the second step pairs it.
   assign pair   = (state_ff == ST_SECOND) ? {ram_rdata, word0_ff} : {32'h0, ram_rdata};
   assign merged = merge(pair, item_data_ff, item_bo_ff, item_size_ff);
   assign result_data = (item_io_ff || item_cmd_ff == CMD_WRITE) ? 32'h0
                        : extract(pair, item_bo_ff, item_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (!item_io_ff && item_two_ff) begin
               state_in = ST_SECOND;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (item_cmd_ff == CMD_WRITE) begin
               state_in = ST_WRBACK;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRBACK: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Writes held over a stalled result repeat the same value, so they are harmless.
   always_comb begin
      ram_ctl   = '0;
      ram_addr  = item_w0_ff;
      ram_wdata = merged[31:0];
      produce   = 1'b0;
      word0_in  = word0_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_ctl.re = accept;
            ram_addr   = in_w0[IDX_W-1:0];
         end
         ST_FIRST: begin
            if (!item_io_ff && item_two_ff) begin
               ram_ctl.re = 1'b1;
               ram_addr   = item_w1_ff;
               word0_in   = ram_rdata;
            end else begin
               ram_ctl.we = !item_io_ff && (item_cmd_ff == CMD_WRITE);
               produce    = 1'b1;
            end
         end
         ST_SECOND: begin
            if (item_cmd_ff == CMD_WRITE) begin
               ram_ctl.we = 1'b1;
               ram_addr   = item_w1_ff;
               ram_wdata  = merged[63:32];
               word0_in   = merged[31:0];
            end else begin
               produce = 1'b1;
            end
         end
         ST_WRBACK: begin
            ram_ctl.we = 1'b1;
            ram_wdata  = word0_ff;
            produce    = 1'b1;
         end
         default: begin
            ram_ctl = '0;
         end
      endcase
   end

   umau_ram #(
      .DEPTH (RAM_WORDS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Output register parts the result beat from the sequencer.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (produce && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (produce && slot_free) begin
         rsp_tdata <= result_data;
         rsp_tuser <= item_io_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // An I/O access must never modify RAM.
   a_io_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && item_io_ff) |-> !ram_ctl.we)
      else $error("RAM written during an I/O access");

   // An accepted beat always starts with the first longword step.
   a_accept_first: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FIRST))
      else $error("accepted beat did not enter the first step");

   // The second step exists only for accesses that cross a longword boundary.
   a_second_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECOND || state_ff == ST_WRBACK) |-> (item_two_ff && !item_io_ff))
      else $error("second longword step for a non-crossing access");

   // A new result beat is only created by an active step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) != ST_IDLE))
      else $error("result beat raised from idle");

endmodule

`default_nettype wire

/* verif/unaligned_memory_access_unit_core_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register ports. It keeps its own image of the RAM,
// works out the result of every accepted request beat and compares each result beat
// with the oldest result still owed.
module unaligned_memory_access_unit_core_checker #(
   parameter int unsigned RAM_WORDS      = umau_pkg::RAM_WORDS_DEFAULT,
   parameter int unsigned PHYS_ADDR_BITS = umau_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [63:0] req_tdata,
   input  wire  [2:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [31:0] rsp_tdata,
   input  wire         rsp_tuser,
   input  wire         csr_we,
   input  wire  [umau_pkg::RAM_BYTES_W-1:0] csr_wdata,
   output int          mismatches,
   output int          replies_pending
);

   localparam int unsigned IDX_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

   typedef struct packed {
      logic [31:0] read_data;
      logic        io_access;
   } access_reply_type;

   bit   [31:0]                      ram_image [RAM_WORDS];
   logic [umau_pkg::RAM_BYTES_W-1:0] ram_bytes_q;
   access_reply_type                 replies_due [$];

   // A longword counts as RAM only if all four of its bytes lie below the size.
   function automatic bit longword_in_ram(input longint unsigned w);
      return (w < 64'(RAM_WORDS)) && ((w * 4 + 3) < 64'(ram_bytes_q));
   endfunction

   function automatic access_reply_type apply_access(input logic is_write,
                                                     input logic [29:0] addr,
                                                     input logic [31:0] data,
                                                     input logic [1:0] size);
      access_reply_type  reply;
      longint unsigned   word_mask;
      longint unsigned   lo_word;
      longint unsigned   hi_word;
      int unsigned       nbytes;
      int unsigned       shift;
      bit                spans;
      logic [63:0]       pair;
      logic [63:0]       field;
      logic [63:0]       lanes;
      word_mask = (64'd1 << (PHYS_ADDR_BITS - 2)) - 64'd1;
      case (size)
         umau_pkg::SIZE_BYTE: nbytes = 1;
         umau_pkg::SIZE_WORD: nbytes = 2;
         default:             nbytes = 4;
      endcase
      shift   = 32'(addr[1:0]) * 8;
      lo_word = 64'(addr) >> 2;
      hi_word = (lo_word + 1) & word_mask;
      spans   = (32'(addr[1:0]) + nbytes) > 4;
      reply.read_data = '0;
      reply.io_access = 1'b1;
      if (!longword_in_ram(lo_word) || (spans && !longword_in_ram(hi_word))) begin
         return reply;
      end
      reply.io_access = 1'b0;
      field = (64'd1 << (nbytes * 8)) - 64'd1;
      lanes = field << shift;
      pair  = {(spans ? ram_image[IDX_W'(hi_word)] : 32'h0), ram_image[IDX_W'(lo_word)]};
      if (is_write == umau_pkg::CMD_WRITE) begin
         pair = (pair & ~lanes) | (({32'h0, data} << shift) & lanes);
         ram_image[IDX_W'(lo_word)] = pair[31:0];
         if (spans) begin
            ram_image[IDX_W'(hi_word)] = pair[63:32];
         end
      end else begin
         field = (pair >> shift) & field;
         reply.read_data = field[31:0];
      end
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      access_reply_type due;
      if (reset) begin
         ram_bytes_q = umau_pkg::RAM_BYTES_RESET;
         replies_due.delete();
      end else begin
         // The result beat is always older than a request beat taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: result beat with nothing owed, read_data %h io_access %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_tdata !== due.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, due.read_data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== due.io_access) begin
                  $display("%0t: io_access expected %b actual %b",
                           $time, due.io_access, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            ram_bytes_q = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_access(req_tuser[0], req_tdata[29:0],
                                               req_tdata[61:30], req_tuser[2:1]));
         end
      end
      replies_pending = replies_due.size();
   end

endmodule

/* verif/unaligned_memory_access_unit_core_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the unaligned memory access unit. The checker beside the
// block does all prediction and comparison; this module only makes request beats,
// programs the RAM size between phases, stalls the result channel and reports.
module unaligned_memory_access_unit_core_tb;

   localparam int unsigned RAM_WORDS      = umau_pkg::RAM_WORDS_DEFAULT;
   localparam int unsigned PHYS_ADDR_BITS = umau_pkg::PHYS_ADDR_BITS_DEFAULT;
   localparam longint unsigned WORD_MASK  = (64'd1 << (PHYS_ADDR_BITS - 2)) - 64'd1;
   localparam int unsigned IDX_W          = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

   // Size and command codes that the package leaves unnamed.
   localparam logic [1:0] SIZE_LONG     = 2'd2;
   localparam logic [1:0] SIZE_LONG_ALT = 2'd3;
   localparam logic       CMD_READ      = 1'b0;

   // Random accesses cluster on a small window of longwords so that most of them
   // hit RAM that has already been written.
   localparam int unsigned HOT_WORDS      = 12;
   localparam int unsigned PHASE_ITEMS    = 225;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [29:0] phys_address, [61:30] write_data, zero pad
   logic [2:0]  req_tuser = '0;   // [0] command, [2:1] size_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] read_data
   logic        rsp_tuser;        // [0] io_access
   logic        csr_we = 1'b0;
   logic [umau_pkg::RAM_BYTES_W-1:0] csr_wdata = '0;

   int          mismatches;
   int          replies_pending;

   // Idling odds in percent, changed by phase.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // The stimulus side's view of the RAM: which size is programmed and which longwords
   // hold defined data. Nothing may read a longword before it was stored whole.
   int unsigned ram_bytes_set = 32'(umau_pkg::RAM_BYTES_RESET);
   int unsigned hot_base = 0;
   bit          word_ready [RAM_WORDS];
   int unsigned ram_size_plan [6] = '{262144, 1031, 0, 64, 262143, 262144};
   int unsigned idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   unaligned_memory_access_unit_core #(
      .RAM_WORDS      (RAM_WORDS),
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   unaligned_memory_access_unit_core_checker #(
      .RAM_WORDS      (RAM_WORDS),
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .replies_pending (replies_pending)
   );

   // The result channel stalls at random; the odds follow the current phase.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // The watchdog ends a run in which no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("unaligned_memory_access_unit_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int unsigned access_bytes(input logic [1:0] size);
      case (size)
         umau_pkg::SIZE_BYTE: return 1;
         umau_pkg::SIZE_WORD: return 2;
         default:             return 4;
      endcase
   endfunction

   function automatic bit lies_in_ram(input longint unsigned w);
      return (w < 64'(RAM_WORDS)) && ((w * 4 + 3) < 64'(ram_bytes_set));
   endfunction

   // True when the access would read a longword that holds no defined data yet. An I/O
   // access touches nothing, and a whole aligned longword store needs no old data.
   function automatic bit reads_unset_ram(input logic cmd, input logic [29:0] addr,
                                          input logic [1:0] size);
      longint unsigned lo_word;
      longint unsigned hi_word;
      bit              spans;
      bit              full_store;
      lo_word = 64'(addr) >> 2;
      hi_word = (lo_word + 1) & WORD_MASK;
      spans   = (32'(addr[1:0]) + access_bytes(size)) > 4;
      if (!lies_in_ram(lo_word) || (spans && !lies_in_ram(hi_word))) begin
         return 1'b0;
      end
      full_store = (cmd == umau_pkg::CMD_WRITE) && (addr[1:0] == 2'b00) &&
                   (access_bytes(size) == 4);
      return !full_store && (!word_ready[IDX_W'(lo_word)] ||
                             (spans && !word_ready[IDX_W'(hi_word)]));
   endfunction

   // Presents one request beat at a falling edge, after any random idle cycles, and
   // returns at the rising edge that takes it. Valid stays high until the next call
   // or until the caller lowers it.
   task automatic send_access(input logic cmd, input logic [29:0] addr,
                              input logic [31:0] data, input logic [1:0] size);
      if ((cmd == umau_pkg::CMD_WRITE) && (addr[1:0] == 2'b00) &&
          (access_bytes(size) == 4) && lies_in_ram(64'(addr) >> 2)) begin
         word_ready[IDX_W'(addr >> 2)] = 1'b1;
      end
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {2'b00, data, addr};
      req_tuser  = {size, cmd};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // One random access. Most land in the hot window, some straddle the top of the
   // installed RAM, some sit at the bottom, and the rest use the whole address space
   // so every address bit toggles. An access that would read undefined RAM becomes a
   // whole longword store to the same longword, which then makes it readable.
   task automatic random_access();
      logic        cmd;
      logic [29:0] addr;
      logic [1:0]  size;
      int          pick;
      int          near_top;
      pick = $urandom_range(99);
      cmd  = 1'($urandom_range(1));
      size = 2'($urandom_range(3));
      if (pick < 60) begin
         addr = 30'((hot_base + $urandom_range(HOT_WORDS - 1)) * 4 + $urandom_range(3));
      end else if (pick < 75) begin
         near_top = int'(ram_bytes_set) - 8 + int'($urandom_range(15));
         if (near_top < 0) begin
            near_top = 0;
         end
         addr = 30'(near_top);
      end else if (pick < 85) begin
         addr = 30'($urandom_range(63));
      end else begin
         addr = 30'($urandom());
      end
      if (reads_unset_ram(cmd, addr, size)) begin
         cmd       = umau_pkg::CMD_WRITE;
         size      = SIZE_LONG;
         addr[1:0] = 2'b00;
      end
      send_access(cmd, addr, $urandom(), size);
   endtask

   // The size register is written only with the block idle, once every result is in.
   task automatic program_ram_size(input int unsigned value);
      int unsigned full_words;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (replies_pending != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value[umau_pkg::RAM_BYTES_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      ram_bytes_set = value;
      full_words = ram_bytes_set / 4;
      if (full_words > RAM_WORDS) begin
         full_words = RAM_WORDS;
      end
      hot_base = (full_words > HOT_WORDS) ? $urandom_range(full_words - HOT_WORDS) : 0;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Sender idles lightly while the receiver stalls hard.
      req_idle_pct  = 20;
      rsp_stall_pct = 86;

      // Directed part at the reset size. Seed the first four longwords, including the
      // all-ones and all-zeros patterns and a store with size code three.
      send_access(umau_pkg::CMD_WRITE, 30'h0, 32'hFFFF_FFFF, SIZE_LONG);
      send_access(umau_pkg::CMD_WRITE, 30'h4, 32'h0000_0000, SIZE_LONG_ALT);
      send_access(umau_pkg::CMD_WRITE, 30'h8, 32'h89AB_CDEF, SIZE_LONG);
      send_access(umau_pkg::CMD_WRITE, 30'hC, 32'h0123_4567, SIZE_LONG);
      // Reads inside one longword and across a boundary; the data field is ignored.
      send_access(CMD_READ, 30'h1, $urandom(), umau_pkg::SIZE_BYTE);
      send_access(CMD_READ, 30'h3, $urandom(), umau_pkg::SIZE_WORD);
      send_access(CMD_READ, 30'h2, $urandom(), umau_pkg::SIZE_WORD);
      send_access(CMD_READ, 30'h2, $urandom(), SIZE_LONG);
      send_access(CMD_READ, 30'h7, $urandom(), SIZE_LONG_ALT);
      // Partial and unaligned stores: of a byte or word only the low byte or word may land, merged across longwords.
      send_access(umau_pkg::CMD_WRITE, 30'h5, 32'hA5A5_A5A5, umau_pkg::SIZE_BYTE);
      send_access(umau_pkg::CMD_WRITE, 30'h7, 32'hFFFF_1234, umau_pkg::SIZE_WORD);
      send_access(umau_pkg::CMD_WRITE, 30'hB, 32'hDEAD_BEEF, SIZE_LONG);
      send_access(CMD_READ, 30'h4, $urandom(), SIZE_LONG);
      send_access(CMD_READ, 30'h8, $urandom(), SIZE_LONG);
      send_access(CMD_READ, 30'hC, $urandom(), SIZE_LONG);
      send_access(CMD_READ, 30'hE, $urandom(), umau_pkg::SIZE_BYTE);
      // Top longword of the RAM, its last byte, then accesses that run one and two bytes past it.
      send_access(umau_pkg::CMD_WRITE, 30'h3FFFC, 32'h5A5A_5A5A, SIZE_LONG);
      send_access(CMD_READ, 30'h3FFFF, $urandom(), umau_pkg::SIZE_BYTE);
      send_access(CMD_READ, 30'h3FFFF, $urandom(), umau_pkg::SIZE_WORD);
      send_access(umau_pkg::CMD_WRITE, 30'h3FFFE, 32'h1357_9BDF, SIZE_LONG);
      // Beyond the RAM, and a longword that wraps past the top of the address space.
      send_access(CMD_READ, 30'h40000, $urandom(), SIZE_LONG);
      send_access(CMD_READ, 30'h3FFF_FFFF, $urandom(), SIZE_LONG);
      send_access(umau_pkg::CMD_WRITE, 30'h3FFF_FFFF, 32'hFFFF_FFFF, umau_pkg::SIZE_WORD);

      // Random phases. Each programs a new RAM size: full size, odd sizes whose last
      // longword is partial, no RAM at all, and a tiny RAM.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            req_idle_pct  = 86;
            rsp_stall_pct = 20;
         end else if (phase == 4) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         program_ram_size(ram_size_plan[phase]);
         repeat (PHASE_ITEMS) random_access();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (replies_pending != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if ((mismatches == 0) && (replies_pending == 0)) begin
         $display("unaligned_memory_access_unit_core_tb: done, clean");
      end else begin
         $display("unaligned_memory_access_unit_core_tb: done, errors");
      end
      $finish;
   end

endmodule
